[design/oaht_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table package
// Shared widths, codes and request/result types for the open-addressing table.
// ----------------------------------------------------------------------------
package oaht_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_KEY_BYTES   = 8;

  localparam int OP_W     = 2;
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int SLOT_W   = 10;
  localparam int FREE_W   = 11;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W    = 11;
  localparam int FRAC_W   = 24;

  // Fractional multiplier, about 0.22626 as a 24-bit fraction.
  localparam logic [FRAC_W-1:0] MULT_FRAC = 24'd3795946;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_MODE  = 2'd1;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] found_value;
    logic [SLOT_W-1:0]       slot_index;
    logic [FREE_W-1:0]       free_count;
  } out_res_t;

endpackage

[design/oaht_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/oaht_mod.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring remainder of the byte sum by the table size, one bit per cycle.
// ----------------------------------------------------------------------------
module oaht_mod
  import oaht_pkg::*;
#(
  parameter int SIZE_W = 11,
  parameter int IDX_W  = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              done,
  output logic [IDX_W-1:0]  rem
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  q_r, q_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [SIZE_W:0]   trial;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, q_r[SUM_W-1]};
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(SUM_W);
      q_nxt   = dividend;
      rem_nxt = '0;
    end else if (run_r) begin
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      rem_nxt = trial[SIZE_W-1:0];
      q_nxt   = {q_r[SUM_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = IDX_W'(rem_r);

endmodule

[design/open_addressing_hash_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Open-addressing hash table
// Key/value store with linear probing in one slot RAM.
// ----------------------------------------------------------------------------
// Home slot: a multiplicative-mode insert computes it in S_MUL1 and S_MUL2; lookups
// and modular-mode inserts wait in S_MOD for the remainder unit. S_PROBE then reads
// one slot after another, wrapping at table_size, until a hit or a full miss.
// Throughput: one request at a time; the probe loop over the RAM read port sets
// the rate. Results are single-cycle strobes and the receiver cannot stall.
// Reset (and any table_size write) runs a clearing pass over every slot.
module open_addressing_hash_table
  import oaht_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BYTES   = DEF_KEY_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_req_t              in_req,
  output logic                 out_valid,
  output out_res_t             out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int SIZE_W = $clog2(TABLE_DEPTH + 1);
  localparam int KB_W   = 8 * KEY_BYTES;
  localparam int WORD_W = 1 + KB_W + VAL_W;
  localparam int CMP_W  = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_MUL1  = 3'd3;
  localparam logic [2:0] S_MUL2  = 3'd4;
  localparam logic [2:0] S_PROBE = 3'd5;

  // Control state.
  logic [2:0]        state_r, state_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic              mode_r, mode_nxt;
  logic [SIZE_W-1:0] free_r, free_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic              report_r, report_nxt;
  logic [SIZE_W-1:0] iss_r, iss_nxt;
  logic              rv_r, rv_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Request payload and probe position.
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [KB_W-1:0]   key_r, key_nxt;
  logic [VAL_W-1:0]  value_r, value_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [IDX_W-1:0]  rpos_r, rpos_nxt;
  out_res_t          res_r, res_nxt;

  logic              accept;
  logic [SUM_W-1:0]  sum_c;
  logic              mod_go;
  logic              mod_done;
  logic [IDX_W-1:0]  mod_rem;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  logic              rd_used;
  logic [KB_W-1:0]   rd_key;
  logic [VAL_W-1:0]  rd_val;
  logic              hit;
  logic [SIZE_W+FRAC_W-1:0] home_prod;

  assign accept = start && (state_r == S_IDLE);

  // Home hash: sum of the first five key bytes, unsigned.
  assign sum_c = SUM_W'(in_req.key[7:0]) + SUM_W'(in_req.key[15:8])
               + SUM_W'(in_req.key[23:16]) + SUM_W'(in_req.key[31:24])
               + SUM_W'(in_req.key[39:32]);

  // The remainder unit serves lookups and modular-mode inserts.
  assign mod_go = accept && (size_r != '0) &&
                  ((in_req.op == OP_LOOKUP) ||
                   ((in_req.op == OP_INSERT) && !mode_r && (free_r != '0)));

  oaht_mod #(
    .SIZE_W (SIZE_W),
    .IDX_W  (IDX_W)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (mod_go),
    .dividend (sum_c),
    .divisor  (size_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Slot word: used flag, key, value.
  oaht_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  assign rd_used = ram_rdata[WORD_W-1];
  assign rd_key  = ram_rdata[WORD_W-2 -: KB_W];
  assign rd_val  = ram_rdata[VAL_W-1:0];

  // The data returning from the previous probe read decides the request:
  // an insert wants an unused slot, a lookup a used slot with an equal key.
  assign hit = rv_r && ((op_r == OP_INSERT) ? !rd_used :
                        (rd_used && (rd_key == key_r)));

  assign home_prod = {{FRAC_W{1'b0}}, size_r} * {{SIZE_W{1'b0}}, frac_r};

  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    mode_nxt      = mode_r;
    free_nxt      = free_r;
    ptr_nxt       = ptr_r;
    report_nxt    = report_r;
    iss_nxt       = iss_r;
    rv_nxt        = 1'b0;
    out_valid_nxt = 1'b0;
    op_nxt        = op_r;
    key_nxt       = key_r;
    value_nxt     = value_r;
    frac_nxt      = frac_r;
    pos_nxt       = pos_r;
    rpos_nxt      = pos_r;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    ram_waddr     = ptr_r;
    ram_wdata     = '0;

    case (state_r)
      S_CLEAR: begin
        // Clearing pass: write every slot as unused.
        ram_we  = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == IDX_W'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
          free_nxt  = size_r;
          if (report_r) begin
            out_valid_nxt       = 1'b1;
            res_nxt.status      = ST_OK;
            res_nxt.found_value = '0;
            res_nxt.slot_index  = '0;
            res_nxt.free_count  = FREE_W'(size_r);
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt              = in_req.op;
          key_nxt             = in_req.key[KB_W-1:0];
          value_nxt           = in_req.value;
          res_nxt.status      = ST_OK;
          res_nxt.found_value = '0;
          res_nxt.slot_index  = '0;
          res_nxt.free_count  = FREE_W'(free_r);
          frac_nxt            = FRAC_W'(FRAC_W'(sum_c) * MULT_FRAC);
          case (in_req.op)
            OP_INSERT: begin
              if ((size_r == '0) || (free_r == '0)) begin
                res_nxt.status = ST_FULL;
                out_valid_nxt  = 1'b1;
              end else if (mode_r) begin
                state_nxt = S_MUL1;
              end else begin
                state_nxt = S_MOD;
              end
            end
            OP_LOOKUP: begin
              if (size_r == '0) begin
                res_nxt.status = ST_EMPTY;
                out_valid_nxt  = 1'b1;
              end else begin
                state_nxt = S_MOD;
              end
            end
            OP_CLEAR: begin
              state_nxt  = S_CLEAR;
              ptr_nxt    = '0;
              report_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          pos_nxt   = mod_rem;
          iss_nxt   = '0;
          state_nxt = S_PROBE;
        end
      end
      S_MUL1: begin
        // The fraction product was registered at accept; S_MUL2 scales it by the table size.
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        pos_nxt   = IDX_W'(home_prod >> FRAC_W);
        iss_nxt   = '0;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (hit) begin
          state_nxt          = S_IDLE;
          out_valid_nxt      = 1'b1;
          res_nxt.status     = ST_OK;
          res_nxt.slot_index = SLOT_W'(rpos_r);
          if (op_r == OP_INSERT) begin
            ram_we             = 1'b1;
            ram_waddr          = rpos_r;
            ram_wdata          = {1'b1, key_r, value_r};
            free_nxt           = free_r - 1'b1;
            res_nxt.free_count = FREE_W'(free_r - 1'b1);
          end else begin
            res_nxt.found_value = rd_val;
            res_nxt.free_count  = FREE_W'(free_r);
          end
        end else if (iss_r != size_r) begin
          // Issue the next circular probe read.
          rv_nxt  = 1'b1;
          iss_nxt = iss_r + 1'b1;
          pos_nxt = ((SIZE_W'(pos_r) + 1'b1) == size_r) ? '0 : pos_r + 1'b1;
        end else if (!rv_r) begin
          // Every slot in use was probed without success.
          state_nxt           = S_IDLE;
          out_valid_nxt       = 1'b1;
          res_nxt.status      = (op_r == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
          res_nxt.found_value = '0;
          res_nxt.slot_index  = '0;
          res_nxt.free_count  = FREE_W'(free_r);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Configuration writes must arrive only while idle; the block itself does not enforce this.
    if (cfg_we) begin
      case (cfg_idx)
        REG_TABLE_SIZE: begin
          if (CMP_W'(cfg_wdata) > CMP_W'(TABLE_DEPTH)) begin
            size_nxt = SIZE_W'(TABLE_DEPTH);
          end else begin
            size_nxt = SIZE_W'(cfg_wdata);
          end
          state_nxt  = S_CLEAR;
          ptr_nxt    = '0;
          report_nxt = 1'b0;
        end
        REG_HASH_MODE: begin
          mode_nxt = cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      size_r      <= SIZE_W'(TABLE_DEPTH);
      mode_r      <= 1'b0;
      free_r      <= SIZE_W'(TABLE_DEPTH);
      ptr_r       <= '0;
      report_r    <= 1'b0;
      iss_r       <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      mode_r      <= mode_nxt;
      free_r      <= free_nxt;
      ptr_r       <= ptr_nxt;
      report_r    <= report_nxt;
      iss_r       <= iss_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    value_r <= value_nxt;
    frac_r  <= frac_nxt;
    pos_r   <= pos_nxt;
    rpos_r  <= rpos_nxt;
    res_r   <= res_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule
